// File: rtl/sba_pkg.sv
`timescale 1ns / 1ps

package sba_pkg;

    localparam int SBA_MAX_SLOTS = 32;
    localparam int SLOT_W        = 6;
    localparam int SCAN_W        = SLOT_W + 1;
    localparam int ADDR_W        = 32;
    localparam int PREFIX_W      = 6;
    localparam int REG_IDX_W     = 2;

    localparam logic [PREFIX_W-1:0] PREFIX_MAX   = PREFIX_W'(32);
    localparam logic [PREFIX_W-1:0] PREFIX_RESET = PREFIX_W'(24);

    localparam logic [REG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PREFIX_BITS  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SLOT_COUNT   = 2'd2;

    localparam logic OP_ALLOCATE = 1'b0;
    localparam logic OP_RELEASE  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_SLOT   = 2'd1;
    localparam logic [1:0] STATUS_IN_USE    = 2'd2;
    localparam logic [1:0] STATUS_SLOT_ZERO = 2'd3;

    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] slot_index;
    } sba_req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [SLOT_W-1:0]   granted_slot;
        logic [ADDR_W-1:0]   subnet_address;
        logic [PREFIX_W-1:0] subnet_prefix;
    } sba_rsp_t;

    typedef struct packed {
        logic [REG_IDX_W-1:0] reg_index;
        logic [ADDR_W-1:0]    reg_data;
    } sba_cfg_t;

endpackage

// File: rtl/sba_stream_if.sv
`timescale 1ns / 1ps

interface sba_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

// File: rtl/subnet_bitmap_allocator.sv
`timescale 1ns / 1ps

// Subnet slot allocator over a bitmap of up to MAX_SLOTS slots, numbered 1..count.
// Channels: req (sink) takes one item {operation, slot_index}; rsp (source) gives one
// item {status, granted_slot, subnet_address, subnet_prefix} for every request;
// cfg (sink, always ready) writes base_address (0), prefix_bits (1), slot_count (2).
// Write cfg only while no request is in flight.
// Flow: a release or an allocate of a named slot goes from idle to the check state, which
// loads the result register once it is free. An allocate with index 0 first walks the bitmap
// one slot per cycle in a single compare unit, past the used slots below the first free
// one, and then goes to the check state. One request is in work at a time; req.ready is
// high only while the sequencer is idle, so a new request is taken only after the last one
// has left the check state.
// Reset: all slots free, base_address 0, prefix_bits 24, slot_count 0.
// Stall: a finished result waits in the output register; the next request is taken
// meanwhile and finishes only when that register is free, holding the bitmap unchanged.
module subnet_bitmap_allocator
    import sba_pkg::*;
#(
    parameter int MAX_SLOTS = SBA_MAX_SLOTS
)
(
    input  logic         clk,
    input  logic         rst_n,
    sba_stream_if.sink   req,
    sba_stream_if.source rsp,
    sba_stream_if.sink   cfg
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic                 op_reg, op_next;
    logic [SCAN_W-1:0]    slot_reg, slot_next;
    logic [MAX_SLOTS-1:0] map_reg, map_next;
    logic [ADDR_W-1:0]    base_reg;
    logic [PREFIX_W-1:0]  prefix_reg;
    logic [SLOT_W-1:0]    count_reg;
    logic                 out_valid_reg, out_valid_next;
    sba_rsp_t             out_reg, out_next;

    sba_req_t             req_item;
    sba_cfg_t             cfg_item;
    logic [SCAN_W-1:0]    eff_count;
    logic [PREFIX_W-1:0]  eff_prefix;
    logic [SLOT_W-1:0]    bit_pos;
    logic [MAX_SLOTS-1:0] slot_mask;
    logic                 slot_used;
    logic                 in_range;
    logic                 out_free;
    logic [ADDR_W-1:0]    slot_address;
    logic [1:0]           status;

    assign req_item  = req.data;
    assign cfg_item  = cfg.data;
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    assign eff_count  = (count_reg > SLOT_W'(MAX_SLOTS)) ? SCAN_W'(MAX_SLOTS)
                                                          : SCAN_W'(count_reg);
    assign eff_prefix = (prefix_reg > PREFIX_MAX) ? PREFIX_MAX : prefix_reg;
    assign bit_pos    = slot_reg[SLOT_W-1:0] - SLOT_W'(1);
    assign slot_mask  = MAX_SLOTS'(1) << bit_pos;
    assign in_range   = (slot_reg != '0) && (slot_reg <= eff_count);
    assign slot_used  = |(map_reg & slot_mask);
    assign out_free   = !out_valid_reg || rsp.ready;

    sba_addr_unit u_addr (
        .slot           (slot_reg[SLOT_W-1:0]),
        .base_address   (base_reg),
        .prefix         (eff_prefix),
        .subnet_address (slot_address)
    );

    always_comb
    begin
        if (op_reg == OP_ALLOCATE)
        begin
            if (!in_range)
            begin
                status = STATUS_NO_SLOT;
            end
            else if (slot_used)
            begin
                status = STATUS_IN_USE;
            end
            else
            begin
                status = STATUS_OK;
            end
        end
        else
        begin
            if (slot_reg == '0)
            begin
                status = STATUS_SLOT_ZERO;
            end
            else if (!in_range)
            begin
                status = STATUS_NO_SLOT;
            end
            else
            begin
                status = STATUS_OK;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        slot_next      = slot_reg;
        map_next       = map_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next = req_item.operation;
                    if (req_item.operation == OP_ALLOCATE && req_item.slot_index == '0)
                    begin
                        slot_next  = SCAN_W'(1);
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        slot_next  = SCAN_W'(req_item.slot_index);
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_SCAN:
            begin
                // advance past used slots; stop on the first free or past the count
                if (in_range && slot_used)
                begin
                    slot_next = slot_reg + SCAN_W'(1);
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next.status = status;
                    if (status == STATUS_OK)
                    begin
                        out_next.granted_slot   = slot_reg[SLOT_W-1:0];
                        out_next.subnet_address = slot_address;
                        out_next.subnet_prefix  = eff_prefix;
                        if (op_reg == OP_ALLOCATE)
                        begin
                            map_next = map_reg | slot_mask;
                        end
                        else
                        begin
                            map_next = map_reg & ~slot_mask;
                        end
                    end
                    else
                    begin
                        out_next.granted_slot   = '0;
                        out_next.subnet_address = '0;
                        out_next.subnet_prefix  = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            map_reg       <= '0;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
            prefix_reg    <= PREFIX_RESET;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            map_reg       <= map_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg_item.reg_index)
                    REG_BASE_ADDRESS: base_reg   <= cfg_item.reg_data;
                    REG_PREFIX_BITS:  prefix_reg <= cfg_item.reg_data[PREFIX_W-1:0];
                    REG_SLOT_COUNT:   count_reg  <= cfg_item.reg_data[SLOT_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        slot_reg <= slot_next;
        out_reg  <= out_next;
    end

endmodule

// File: rtl/sba_addr_unit.sv
`timescale 1ns / 1ps

module sba_addr_unit
    import sba_pkg::*;
(
    input  logic [SLOT_W-1:0]   slot,
    input  logic [ADDR_W-1:0]   base_address,
    input  logic [PREFIX_W-1:0] prefix,
    output logic [ADDR_W-1:0]   subnet_address
);

    logic [SLOT_W-1:0]   offset;
    logic [PREFIX_W-1:0] shift;
    logic [ADDR_W-1:0]   step_offset;

    always_comb
    begin
        offset = slot - SLOT_W'(1);
        shift  = PREFIX_MAX - prefix;
        // a shift of the full word leaves every slot at the base
        if (shift[5])
        begin
            step_offset = '0;
        end
        else
        begin
            step_offset = ADDR_W'(offset) << shift[4:0];
        end
        subnet_address = base_address + step_offset;
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sba_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;

    logic clk = 1'b0;
    logic rst_n;

    sba_stream_if #(.payload_t(sba_req_t)) req_if ();
    sba_stream_if #(.payload_t(sba_rsp_t)) rsp_if ();
    sba_stream_if #(.payload_t(sba_cfg_t)) cfg_if ();

    subnet_bitmap_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    always #5 clk = ~clk;

    logic [ADDR_W-1:0]        pool_base;
    logic [PREFIX_W-1:0]      pool_prefix;
    logic [SLOT_W-1:0]        pool_count;
    logic [SBA_MAX_SLOTS-1:0] slot_map;

    sba_rsp_t pending_grants[$];
    sba_cfg_t staged_writes[$];
    sba_rsp_t want_grant;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic rsp_hold = 1'b0;

    int requests_sent   = 0;
    int results_checked = 0;
    int register_writes = 0;
    int mismatches      = 0;
    int stalled_cycles  = 0;
    int status_seen[4]  = '{0, 0, 0, 0};

    function automatic int live_slots();
        return (pool_count > SBA_MAX_SLOTS) ? SBA_MAX_SLOTS : int'(pool_count);
    endfunction

    function automatic int live_prefix();
        return (pool_prefix > PREFIX_MAX) ? int'(PREFIX_MAX) : int'(pool_prefix);
    endfunction

    function automatic sba_rsp_t grant_for(sba_req_t r);
        sba_rsp_t g;
        int s;
        int n;
        logic [63:0] addr;
        g = '0;
        s = int'(r.slot_index);
        n = live_slots();
        if (r.operation == OP_ALLOCATE)
        begin
            if (s == 0)
            begin
                s = 1;
                while (s <= n && slot_map[s-1])
                    s++;
            end
            if (s > n)
                g.status = STATUS_NO_SLOT;
            else if (slot_map[s-1])
                g.status = STATUS_IN_USE;
            else
            begin
                slot_map[s-1] = 1'b1;
                g.status = STATUS_OK;
            end
        end
        else
        begin
            if (s == 0)
                g.status = STATUS_SLOT_ZERO;
            else if (s > n)
                g.status = STATUS_NO_SLOT;
            else
            begin
                slot_map[s-1] = 1'b0;
                g.status = STATUS_OK;
            end
        end
        if (g.status == STATUS_OK)
        begin
            addr = {32'b0, pool_base} + (64'(s - 1) << (ADDR_W - live_prefix()));
            g.granted_slot   = SLOT_W'(s);
            g.subnet_address = addr[ADDR_W-1:0];
            g.subnet_prefix  = PREFIX_W'(live_prefix());
        end
        return g;
    endfunction

    function automatic void apply_write(sba_cfg_t w);
        case (w.reg_index)
            REG_BASE_ADDRESS: pool_base   = w.reg_data;
            REG_PREFIX_BITS:  pool_prefix = w.reg_data[PREFIX_W-1:0];
            REG_SLOT_COUNT:   pool_count  = w.reg_data[SLOT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] narrow_value(int v);
        logic [31:0] d;
        d = 32'(v) & 32'h3F;
        if ($urandom_range(3) == 0)
            d = d | ($urandom() & ~32'h3F);
        return d;
    endfunction

    task automatic drain_results();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_grants.size() != 0);
    endtask

    task automatic stage_write(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
        sba_cfg_t w;
        w.reg_index = idx;
        w.reg_data  = data;
        staged_writes.push_back(w);
    endtask

    task automatic apply_staged_writes();
        sba_cfg_t w;
        drain_results();
        while (staged_writes.size() != 0)
        begin
            w = staged_writes.pop_front();
            cfg_if.valid <= 1'b1;
            cfg_if.data  <= w;
            @(posedge clk);
            while (!cfg_if.ready)
                @(posedge clk);
            apply_write(w);
            register_writes++;
        end
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_request(logic op, int idx);
        sba_req_t r;
        r.operation  = op;
        r.slot_index = SLOT_W'(idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        pending_grants.push_back(grant_for(r));
        requests_sent++;
    endtask

    task automatic test_empty_pool();
        send_request(OP_ALLOCATE, 0);
        send_request(OP_ALLOCATE, 1);
        send_request(OP_RELEASE, 1);
        send_request(OP_RELEASE, 0);
    endtask

    task automatic test_first_free();
        stage_write(REG_BASE_ADDRESS, 32'h0A00_0000);
        stage_write(REG_PREFIX_BITS, 32'd24);
        stage_write(REG_SLOT_COUNT, 32'd4);
        apply_staged_writes();
        repeat (5)
            send_request(OP_ALLOCATE, 0);
        send_request(OP_ALLOCATE, 2);
        send_request(OP_ALLOCATE, 5);
        send_request(OP_RELEASE, 3);
        send_request(OP_RELEASE, 3);
        send_request(OP_ALLOCATE, 0);
        send_request(OP_RELEASE, 0);
        send_request(OP_RELEASE, 63);
        send_request(OP_ALLOCATE, 63);
    endtask

    task automatic test_lowered_count();
        stage_write(REG_SLOT_COUNT, 32'd2);
        apply_staged_writes();
        send_request(OP_RELEASE, 3);
        send_request(OP_ALLOCATE, 3);
        stage_write(REG_SLOT_COUNT, 32'd4);
        apply_staged_writes();
        send_request(OP_ALLOCATE, 3);
    endtask

    task automatic test_prefix_extremes();
        stage_write(REG_BASE_ADDRESS, 32'hFFFF_FFFF);
        stage_write(REG_PREFIX_BITS, 32'd0);
        stage_write(REG_SLOT_COUNT, 32'd40);
        stage_write(REG_UNUSED, 32'hFFFF_FFFF);
        apply_staged_writes();
        send_request(OP_ALLOCATE, 32);
        stage_write(REG_PREFIX_BITS, 32'd45);
        apply_staged_writes();
        send_request(OP_ALLOCATE, 31);
        stage_write(REG_PREFIX_BITS, 32'd32);
        apply_staged_writes();
        send_request(OP_ALLOCATE, 30);
        stage_write(REG_PREFIX_BITS, 32'hFFFF_FFC1);
        apply_staged_writes();
        send_request(OP_ALLOCATE, 29);
    endtask

    task automatic configure_random();
        case ($urandom_range(3))
            0: stage_write(REG_BASE_ADDRESS, 32'h0);
            1: stage_write(REG_BASE_ADDRESS, 32'hFFFF_FFFF);
            default: stage_write(REG_BASE_ADDRESS, $urandom());
        endcase
        case ($urandom_range(5))
            0: stage_write(REG_PREFIX_BITS, narrow_value(0));
            1: stage_write(REG_PREFIX_BITS, narrow_value(32));
            2: stage_write(REG_PREFIX_BITS, narrow_value($urandom_range(63, 33)));
            default: stage_write(REG_PREFIX_BITS, narrow_value($urandom_range(31, 8)));
        endcase
        case ($urandom_range(7))
            0: stage_write(REG_SLOT_COUNT, narrow_value(0));
            1: stage_write(REG_SLOT_COUNT, narrow_value(1));
            2: stage_write(REG_SLOT_COUNT, narrow_value(32));
            3: stage_write(REG_SLOT_COUNT, narrow_value($urandom_range(63, 33)));
            default: stage_write(REG_SLOT_COUNT, narrow_value($urandom_range(31, 2)));
        endcase
        if ($urandom_range(7) == 0)
            stage_write(REG_UNUSED, $urandom());
        apply_staged_writes();
    endtask

    task automatic test_random_traffic(int item_total, int send_pct, int recv_pct);
        int sent;
        int burst;
        int n;
        int pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < item_total)
        begin
            configure_random();
            burst = $urandom_range(80, 20);
            for (int i = 0; i < burst && sent < item_total; i++)
            begin
                n = (live_slots() < 1) ? 1 : live_slots();
                pick = $urandom_range(99);
                if (pick < 40)
                    send_request(OP_ALLOCATE, 0);
                else if (pick < 55)
                    send_request(OP_ALLOCATE, $urandom_range(n, 1));
                else if (pick < 85)
                    send_request(OP_RELEASE, $urandom_range(n, 1));
                else
                    send_request(logic'($urandom_range(1)), $urandom_range(63));
                sent++;
            end
        end
        drain_results();
    endtask

    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stage_write(REG_SLOT_COUNT, 32'd32);
        stage_write(REG_PREFIX_BITS, 32'd28);
        apply_staged_writes();
        fork
            begin
                rsp_hold <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                rsp_hold <= 1'b0;
            end
        join_none
        for (int i = 0; i < 16; i++)
            send_request(logic'(i % 3 == 2), (i % 3 == 2) ? i : 0);
        drain_results();
    endtask

    always @(posedge clk)
        rsp_if.ready <= rst_n && !rsp_hold && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            results_checked++;
            if (pending_grants.size() == 0)
            begin
                $error("unexpected result: status %0d slot %0d address %h",
                       rsp_if.data.status, rsp_if.data.granted_slot,
                       rsp_if.data.subnet_address);
                mismatches++;
            end
            else
            begin
                want_grant = pending_grants.pop_front();
                status_seen[want_grant.status]++;
                if (rsp_if.data.status !== want_grant.status)
                begin
                    $error("status: expected %0d, got %0d",
                           want_grant.status, rsp_if.data.status);
                    mismatches++;
                end
                if (rsp_if.data.granted_slot !== want_grant.granted_slot)
                begin
                    $error("granted_slot: expected %0d, got %0d",
                           want_grant.granted_slot, rsp_if.data.granted_slot);
                    mismatches++;
                end
                if (rsp_if.data.subnet_address !== want_grant.subnet_address)
                begin
                    $error("subnet_address: expected %h, got %h",
                           want_grant.subnet_address, rsp_if.data.subnet_address);
                    mismatches++;
                end
                if (rsp_if.data.subnet_prefix !== want_grant.subnet_prefix)
                begin
                    $error("subnet_prefix: expected %0d, got %0d",
                           want_grant.subnet_prefix, rsp_if.data.subnet_prefix);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (cfg_if.valid && cfg_if.ready) || !rst_n)
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     stalled_cycles, pending_grants.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        rsp_if.ready = 1'b0;
        pool_base    = 32'h0;
        pool_prefix  = PREFIX_RESET;
        pool_count   = '0;
        slot_map     = '0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        test_empty_pool();
        test_first_free();
        test_lowered_count();
        test_prefix_extremes();
        test_random_traffic(380, 16, 69);
        test_random_traffic(380, 69, 16);
        test_output_stall();
        test_random_traffic(360, 0, 0);

        drain_results();
        repeat (SBA_MAX_SLOTS + 8)
            @(posedge clk);

        $display("run summary: %0d requests, %0d results, %0d register writes, %0d mismatches",
                 requests_sent, results_checked, register_writes, mismatches);
        $display("result mix: ok %0d, no slot %0d, in use %0d, release of slot zero %0d",
                 status_seen[STATUS_OK], status_seen[STATUS_NO_SLOT],
                 status_seen[STATUS_IN_USE], status_seen[STATUS_SLOT_ZERO]);
        if (mismatches == 0 && pending_grants.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
